// ----- rtl/ccm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants for the composition count block
// Sizes, the count modulus, engine states and the engine request/response
// bundles.
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam int MAX_VALUE = 128;                      // saturation limit of both fields
    localparam int DEPTH     = MAX_VALUE + 1;            // row store entries
    localparam int ADDR_W    = $clog2(DEPTH);            // row store address / total width
    localparam int PART_W    = $clog2(MAX_VALUE + 1);    // saturated part count width
    localparam int CNT_W     = $clog2(MAX_VALUE + 2);    // column counter, runs to total+1
    localparam int FIELD_W   = 8;                        // input field width
    localparam int COUNT_W   = 20;                       // result width

    localparam logic [COUNT_W-1:0] COUNT_MODULUS = COUNT_W'(1000000);
    localparam logic [COUNT_W-1:0] COUNT_ONE     = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_ZERO    = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_PASS,
        ST_FETCH,
        ST_WAIT,
        ST_DONE
    } ccm_state_t;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] parts;
    } ccm_req_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } ccm_rsp_t;

endpackage

// ----- rtl/composition_count_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// composition_count_mod: ordered composition count modulo 1000000
// Counts the ways to write total as an ordered sum of parts nonnegative
// integers, C(total+parts-1, parts-1) mod 1000000, with a row-store engine.
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata fields (low bit up)            notes
//  s_axis    in    total[7:0], parts[15:8]              one transfer per item
//  m_axis    out   count[19:0], zero pad [23:20]        one transfer per item
//
// With T = min(total,128) and P = min(parts,128), an item writes T+1 columns,
// makes P-1 passes over T+2 columns and reads back its result (none of this
// when parts is zero); the single write port of the row store, one column
// per cycle, sets the pace. Reset is asynchronous, active low, and needs no
// clearing pass: each item writes every column whose value it uses.
// One item at a time; the next is taken while a result waits in the output
// register, and a stalled m_axis only holds the engine once it finishes.
// ----------------------------------------------------------------------------
module composition_count_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // total[7:0], parts[15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // count[19:0], zero pad [23:20]
);
    import ccm_pkg::*;

    ccm_req_t           req;
    ccm_rsp_t           rsp;
    logic               req_ready;
    logic               rsp_ready;

    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    assign req.valid     = s_axis_tvalid;
    assign req.total     = s_axis_tdata[7:0];
    assign req.parts     = s_axis_tdata[15:8];
    assign s_axis_tready = req_ready;

    ccm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .rsp       (rsp),
        .rsp_ready (rsp_ready)
    );

    // output register: free, or emptied by a transfer this cycle
    assign rsp_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (rsp.valid && rsp_ready)
        begin
            out_valid_next = 1'b1;
            out_count_next = rsp.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_count_reg};

endmodule

// ----- rtl/ccm_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_engine: row-store sequencer
// Builds the all-ones row, then runs in-place prefix-sum passes over the
// row store memory, one column per cycle, and reads back the final entry.
// ----------------------------------------------------------------------------
module ccm_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  ccm_pkg::ccm_req_t req,
    output logic              req_ready,
    output ccm_pkg::ccm_rsp_t rsp,
    input  logic              rsp_ready
);
    import ccm_pkg::*;

    ccm_state_t state_reg, state_next;
    logic [ADDR_W-1:0]  tot_reg, tot_next;
    logic [PART_W-1:0]  passes_reg, passes_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [COUNT_W-1:0] sum_reg, sum_next;
    logic [COUNT_W-1:0] result_reg, result_next;

    // row store: one write port, one registered read port
    logic [COUNT_W-1:0] row_mem [0:DEPTH-1];
    logic [COUNT_W-1:0] rdata_reg;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [COUNT_W-1:0] wdata;

    logic [31:0]        total_w;
    logic [31:0]        parts_w;
    logic [ADDR_W-1:0]  tot_sat;
    logic [PART_W-1:0]  parts_sat;
    logic [CNT_W-1:0]   tot_ext;
    logic [COUNT_W:0]   add_raw;
    logic [COUNT_W-1:0] add_mod;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        rdata_reg <= row_mem[raddr];
    end

    always_comb
    begin
        total_w   = 32'(req.total);
        parts_w   = 32'(req.parts);
        tot_sat   = (total_w > 32'(MAX_VALUE)) ? ADDR_W'(MAX_VALUE) : ADDR_W'(req.total);
        parts_sat = (parts_w > 32'(MAX_VALUE)) ? PART_W'(MAX_VALUE) : PART_W'(req.parts);
        tot_ext   = CNT_W'(tot_reg);
        add_raw   = {1'b0, sum_reg} + {1'b0, rdata_reg};
        add_mod   = (add_raw >= {1'b0, COUNT_MODULUS})
                    ? COUNT_W'(add_raw - {1'b0, COUNT_MODULUS})
                    : add_raw[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tot_reg    <= '0;
            passes_reg <= '0;
            col_reg    <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tot_reg    <= tot_next;
            passes_reg <= passes_next;
            col_reg    <= col_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        tot_next    = tot_reg;
        passes_next = passes_reg;
        col_next    = col_reg;
        sum_next    = sum_reg;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = col_reg[ADDR_W-1:0];
        wdata       = COUNT_ONE;
        raddr       = col_reg[ADDR_W-1:0];
        req_ready   = 1'b0;
        rsp.valid   = 1'b0;
        rsp.count   = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    tot_next    = tot_sat;
                    passes_next = parts_sat - PART_W'(1);
                    col_next    = '0;
                    if (parts_sat == '0)
                    begin
                        // empty sum: one way only for a zero total
                        result_next = (tot_sat == '0) ? COUNT_ONE : COUNT_ZERO;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end

            ST_FILL:
            begin
                we    = 1'b1;
                wdata = COUNT_ONE;
                if (col_reg == tot_ext)
                begin
                    col_next   = '0;
                    state_next = (passes_reg == '0) ? ST_FETCH : ST_PASS;
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end

            ST_PASS:
            begin
                // read column c; column c-1, read the cycle before, is written now
                if (col_reg == '0)
                begin
                    sum_next = '0;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = ADDR_W'(col_reg - CNT_W'(1));
                    wdata    = add_mod;
                    sum_next = add_mod;
                end
                if (col_reg == tot_ext + CNT_W'(1))
                begin
                    col_next    = '0;
                    passes_next = passes_reg - PART_W'(1);
                    if (passes_reg == PART_W'(1))
                    begin
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end

            ST_FETCH:
            begin
                raddr      = tot_reg;
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                result_next = rdata_reg;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                rsp.valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
